// ===== hdl/tfss_pkg.sv =====
// shared types and constants of the frame slot scheduler
`default_nettype none
package tfss_pkg;

    localparam int SLOT_COUNT_DEF = 3;

    localparam int OP_W     = 3;
    localparam int IDX_IN_W = 4;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 20;
    localparam int CNT_W    = 32;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(33333);

    localparam logic [OP_W-1:0] OP_CLAIM = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd1;
    localparam logic [OP_W-1:0] OP_ABORT = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_FILLING = 2'd1,
        ST_READY   = 2'd2,
        ST_DISPLAY = 2'd3
    } t_slot_st;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAIM,
        S_FILL,
        S_GAP,
        S_CHK,
        S_PICK_A,
        S_PICK_B,
        S_SHOW,
        S_DROP_A,
        S_DROP_B,
        S_FLUSH,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/timestamped_frame_slot_scheduler_top.sv =====
// frame slot scheduler: slot table, scan sequencer and one shared subtractor
//
// channel   direction  handshake                       payload
// input     in         i_in_valid / o_in_ready         operation, slot_index, frame_stamp, now_time
// output    out        o_out_valid / i_out_ready       granted, shown, result_slot, totals
// config    in         psel/penable/pwrite, pready=1   frame_period at byte address 0
//
// one item at a time: the sequencer takes it in, and before it hands the result over claim and
// flush visit the slots once, fill done and abort take one step, a render tick takes two steps
// for the spacing test, up to two per slot for the pick, one to mark the display and up to two
// per slot for the discard pass, with every comparison through the one subtractor.
// reset empties all slots and restores the frame period; stamps are not cleared.
// a stalled output holds the sequencer in its last step until the transfer.
`default_nettype none
module timestamped_frame_slot_scheduler_top #(
    parameter int SLOT_COUNT = tfss_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [tfss_pkg::OP_W-1:0]     i_operation,
    input  wire logic [tfss_pkg::IDX_IN_W-1:0] i_slot_index,
    input  wire logic [tfss_pkg::TIME_W-1:0]   i_frame_stamp,
    input  wire logic [tfss_pkg::TIME_W-1:0]   i_now_time,

    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_granted,
    output logic                               o_shown,
    output logic [tfss_pkg::IDX_IN_W-1:0]      o_result_slot,
    output logic [tfss_pkg::CNT_W-1:0]         o_decoded_total,
    output logic [tfss_pkg::CNT_W-1:0]         o_dropped_total,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tfss_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tfss_pkg::APB_DW-1:0]   pwdata,
    output logic [tfss_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);
    localparam logic [tfss_pkg::IDX_IN_W:0] SLOT_LIM = (tfss_pkg::IDX_IN_W + 1)'(SLOT_COUNT);
    localparam int TW = tfss_pkg::TIME_W;
    localparam int PW = tfss_pkg::PERIOD_W;

    tfss_pkg::t_state   r_state, n_state;
    tfss_pkg::t_slot_st r_status [SLOT_COUNT];
    tfss_pkg::t_slot_st n_status [SLOT_COUNT];
    logic [TW-1:0]      r_stamp_mem [SLOT_COUNT];

    logic [PW-1:0]      r_period;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_pick, n_pick;
    logic               r_have, n_have;
    logic [TW-1:0]      r_pick_stamp, n_pick_stamp;
    logic [TW-1:0]      r_acc, n_acc;
    logic               r_flag, n_flag;
    logic               r_is_fill, n_is_fill;
    logic               r_inrange, n_inrange;
    logic [TW-1:0]      r_stamp_in, n_stamp_in;
    logic [TW-1:0]      r_now, n_now;
    logic [IDX_W-1:0]   r_shown_slot, n_shown_slot;
    logic               r_shown_valid, n_shown_valid;
    logic [TW-1:0]      r_last, n_last;
    logic [tfss_pkg::CNT_W-1:0] r_ready_cnt, n_ready_cnt;
    logic [tfss_pkg::CNT_W-1:0] r_drop_cnt, n_drop_cnt;
    logic               r_res_granted, n_res_granted;
    logic               r_res_shown, n_res_shown;
    logic [tfss_pkg::IDX_IN_W-1:0] r_res_slot, n_res_slot;

    logic               r_out_valid, n_out_valid;
    logic               r_o_granted, n_o_granted;
    logic               r_o_shown, n_o_shown;
    logic [tfss_pkg::IDX_IN_W-1:0] r_o_slot, n_o_slot;
    logic [tfss_pkg::CNT_W-1:0]    r_o_dec, n_o_dec;
    logic [tfss_pkg::CNT_W-1:0]    r_o_drop, n_o_drop;

    logic               stamp_we;
    logic [TW-1:0]      cur_stamp;
    tfss_pkg::t_slot_st cur_status;
    logic [TW-1:0]      unit_a, unit_b;
    logic [TW:0]        unit_res;
    logic               cfg_we;

    assign cur_stamp  = r_stamp_mem[r_idx];
    assign cur_status = r_status[r_idx];
    assign unit_res   = {1'b0, unit_a} - {1'b0, unit_b};

    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {{(tfss_pkg::APB_DW - PW){1'b0}}, r_period};

    assign o_out_valid     = r_out_valid;
    assign o_granted       = r_o_granted;
    assign o_shown         = r_o_shown;
    assign o_result_slot   = r_o_slot;
    assign o_decoded_total = r_o_dec;
    assign o_dropped_total = r_o_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tfss_pkg::S_IDLE;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_status[i] <= tfss_pkg::ST_EMPTY;
            end
            r_period      <= tfss_pkg::PERIOD_RST;
            r_shown_slot  <= '0;
            r_shown_valid <= 1'b0;
            r_last        <= '0;
            r_ready_cnt   <= '0;
            r_drop_cnt    <= '0;
            r_out_valid   <= 1'b0;
            r_have        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_status      <= n_status;
            if (cfg_we) begin
                r_period <= pwdata[PW-1:0];
            end
            r_shown_slot  <= n_shown_slot;
            r_shown_valid <= n_shown_valid;
            r_last        <= n_last;
            r_ready_cnt   <= n_ready_cnt;
            r_drop_cnt    <= n_drop_cnt;
            r_out_valid   <= n_out_valid;
            r_have        <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pick        <= n_pick;
        r_pick_stamp  <= n_pick_stamp;
        r_acc         <= n_acc;
        r_flag        <= n_flag;
        r_is_fill     <= n_is_fill;
        r_inrange     <= n_inrange;
        r_stamp_in    <= n_stamp_in;
        r_now         <= n_now;
        r_res_granted <= n_res_granted;
        r_res_shown   <= n_res_shown;
        r_res_slot    <= n_res_slot;
        r_o_granted   <= n_o_granted;
        r_o_shown     <= n_o_shown;
        r_o_slot      <= n_o_slot;
        r_o_dec       <= n_o_dec;
        r_o_drop      <= n_o_drop;
    end

    // stamp store
    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            r_stamp_mem[r_idx] <= r_stamp_in;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        n_idx         = r_idx;
        n_pick        = r_pick;
        n_have        = r_have;
        n_pick_stamp  = r_pick_stamp;
        n_acc         = r_acc;
        n_flag        = r_flag;
        n_is_fill     = r_is_fill;
        n_inrange     = r_inrange;
        n_stamp_in    = r_stamp_in;
        n_now         = r_now;
        n_shown_slot  = r_shown_slot;
        n_shown_valid = r_shown_valid;
        n_last        = r_last;
        n_ready_cnt   = r_ready_cnt;
        n_drop_cnt    = r_drop_cnt;
        n_res_granted = r_res_granted;
        n_res_shown   = r_res_shown;
        n_res_slot    = r_res_slot;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_o_granted   = r_o_granted;
        n_o_shown     = r_o_shown;
        n_o_slot      = r_o_slot;
        n_o_dec       = r_o_dec;
        n_o_drop      = r_o_drop;
        o_in_ready    = 1'b0;
        stamp_we      = 1'b0;
        unit_a        = r_now;
        unit_b        = cur_stamp;

        unique case (r_state)
            tfss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_is_fill     = (i_operation == tfss_pkg::OP_FILL);
                    n_inrange     = ({1'b0, i_slot_index} < SLOT_LIM);
                    n_stamp_in    = i_frame_stamp;
                    n_now         = i_now_time;
                    n_res_granted = 1'b0;
                    n_res_shown   = 1'b0;
                    n_res_slot    = '0;
                    n_idx         = '0;
                    case (i_operation) inside
                        tfss_pkg::OP_CLAIM: n_state = tfss_pkg::S_CLAIM;
                        tfss_pkg::OP_FILL, tfss_pkg::OP_ABORT: begin
                            n_idx   = i_slot_index[IDX_W-1:0];
                            n_state = tfss_pkg::S_FILL;
                        end
                        tfss_pkg::OP_TICK:  n_state = tfss_pkg::S_GAP;
                        tfss_pkg::OP_FLUSH: n_state = tfss_pkg::S_FLUSH;
                        default:            n_state = tfss_pkg::S_DONE;
                    endcase
                end
            end
            tfss_pkg::S_CLAIM: begin
                if (cur_status == tfss_pkg::ST_EMPTY) begin
                    n_status[r_idx] = tfss_pkg::ST_FILLING;
                    n_res_granted   = 1'b1;
                    n_res_slot      = tfss_pkg::IDX_IN_W'(r_idx);
                    n_state         = tfss_pkg::S_DONE;
                end else if (r_idx == LAST) begin
                    n_state = tfss_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tfss_pkg::S_FILL: begin
                if (r_inrange && cur_status == tfss_pkg::ST_FILLING) begin
                    if (r_is_fill) begin
                        n_status[r_idx] = tfss_pkg::ST_READY;
                        stamp_we        = 1'b1;
                        n_ready_cnt     = r_ready_cnt + 1'b1;
                    end else begin
                        n_status[r_idx] = tfss_pkg::ST_EMPTY;
                    end
                end
                n_state = tfss_pkg::S_DONE;
            end
            tfss_pkg::S_GAP: begin
                unit_a  = r_now;
                unit_b  = r_last;
                n_acc   = unit_res[TW-1:0];
                n_state = tfss_pkg::S_CHK;
            end
            tfss_pkg::S_CHK: begin
                unit_a = r_acc;
                unit_b = TW'(r_period);
                if (unit_res[TW]) begin
                    n_state = tfss_pkg::S_DONE;
                end else begin
                    if (r_shown_valid) begin
                        n_status[r_shown_slot] = tfss_pkg::ST_EMPTY;
                    end
                    n_shown_valid = 1'b0;
                    n_have        = 1'b0;
                    n_idx         = '0;
                    n_state       = tfss_pkg::S_PICK_A;
                end
            end
            tfss_pkg::S_PICK_A: begin
                unit_a = r_now;
                unit_b = cur_stamp;
                if (cur_status == tfss_pkg::ST_READY && r_have) begin
                    n_flag  = !unit_res[TW];
                    n_state = tfss_pkg::S_PICK_B;
                end else begin
                    if (cur_status == tfss_pkg::ST_READY) begin
                        n_have       = 1'b1;
                        n_pick       = r_idx;
                        n_pick_stamp = cur_stamp;
                    end
                    if (r_idx == LAST) begin
                        n_state = tfss_pkg::S_SHOW;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            tfss_pkg::S_PICK_B: begin
                unit_a = r_pick_stamp;
                unit_b = cur_stamp;
                if (r_flag && unit_res[TW]) begin
                    n_pick       = r_idx;
                    n_pick_stamp = cur_stamp;
                end
                if (r_idx == LAST) begin
                    n_state = tfss_pkg::S_SHOW;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = tfss_pkg::S_PICK_A;
                end
            end
            tfss_pkg::S_SHOW: begin
                if (!r_have) begin
                    n_state = tfss_pkg::S_DONE;
                end else begin
                    n_status[r_pick] = tfss_pkg::ST_DISPLAY;
                    n_shown_slot     = r_pick;
                    n_shown_valid    = 1'b1;
                    n_last           = r_now;
                    n_res_shown      = 1'b1;
                    n_res_slot       = tfss_pkg::IDX_IN_W'(r_pick);
                    n_idx            = '0;
                    n_state          = tfss_pkg::S_DROP_A;
                end
            end
            tfss_pkg::S_DROP_A: begin
                unit_a = r_now;
                unit_b = cur_stamp;
                if (r_idx != r_pick && cur_status == tfss_pkg::ST_READY) begin
                    n_acc   = unit_res[TW-1:0];
                    n_flag  = !unit_res[TW];
                    n_state = tfss_pkg::S_DROP_B;
                end else if (r_idx == LAST) begin
                    n_state = tfss_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tfss_pkg::S_DROP_B: begin
                // late when now - stamp exceeds the period
                unit_a = TW'(r_period);
                unit_b = r_acc;
                if (r_flag && unit_res[TW]) begin
                    n_status[r_idx] = tfss_pkg::ST_EMPTY;
                    n_drop_cnt      = r_drop_cnt + 1'b1;
                end
                if (r_idx == LAST) begin
                    n_state = tfss_pkg::S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = tfss_pkg::S_DROP_A;
                end
            end
            tfss_pkg::S_FLUSH: begin
                if (cur_status != tfss_pkg::ST_DISPLAY) begin
                    n_status[r_idx] = tfss_pkg::ST_EMPTY;
                end
                if (r_idx == LAST) begin
                    n_state = tfss_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tfss_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_granted = r_res_granted;
                    n_o_shown   = r_res_shown;
                    n_o_slot    = r_res_slot;
                    n_o_dec     = r_ready_cnt;
                    n_o_drop    = r_drop_cnt;
                    n_state     = tfss_pkg::S_IDLE;
                end
            end
            default: n_state = tfss_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/tfss_checker.sv =====
// port level checks of the frame slot scheduler and their binding
`default_nettype none
module tfss_port_checks #(
    parameter int SLOT_COUNT = tfss_pkg::SLOT_COUNT_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_granted,
    input wire logic                          o_shown,
    input wire logic [tfss_pkg::IDX_IN_W-1:0] o_result_slot,
    input wire logic [tfss_pkg::CNT_W-1:0]    o_decoded_total
);

    localparam logic [tfss_pkg::IDX_IN_W:0] SLOT_LIM = (tfss_pkg::IDX_IN_W + 1)'(SLOT_COUNT);

    // claim and render results never coincide
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && o_shown))
        else $error("granted and shown both set");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted && !o_shown) |-> (o_result_slot == '0))
        else $error("result slot set without a grant or display");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_result_slot} < SLOT_LIM))
        else $error("result slot beyond the slot table");

    // one item in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_decoded_total)))
        else $error("stalled result changed");

endmodule

bind timestamped_frame_slot_scheduler_top tfss_port_checks #(
    .SLOT_COUNT(SLOT_COUNT)
) u_tfss_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_granted      (o_granted),
    .o_shown        (o_shown),
    .o_result_slot  (o_result_slot),
    .o_decoded_total(o_decoded_total)
);
`default_nettype wire
